### src/ssms_pkg.sv
// ----------------------------------------------------------------------------
// ssms_pkg
// Shared constants, types and helpers of the single-sided magnitude spectrum
// unit.
// ----------------------------------------------------------------------------
package ssms_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int MAX_FFT_LOG2 = 16;
	localparam int MIN_FFT_LOG2 = 3;
	localparam int LG_W         = 5;
	localparam int IDX_W        = 16;
	localparam int MAG_W        = 30;

	// a*a + b*b needs 2*SAMPLE_WIDTH bits, the radicand two more for the
	// doubling factor and 16 for the 8 fraction bits of the root
	localparam int SQ_W   = 2 * SAMPLE_WIDTH;
	localparam int X_W    = SQ_W + 18;
	localparam int ROOT_W = X_W / 2;
	localparam int REM_W  = ROOT_W + 1;
	localparam int HALF_W = MAX_FFT_LOG2;
	localparam int CMP_W  = (IDX_W > HALF_W) ? IDX_W : HALF_W;
	localparam int SAT_W  = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;

	localparam int SHIFT_PLAIN  = 16;
	localparam int SHIFT_DOUBLE = 18;

	localparam int S_TDATA_W = ((2 * SAMPLE_WIDTH + IDX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((MAG_W + 7) / 8) * 8;

	localparam logic [LG_W-1:0]  LG_RESET = LG_W'(10);
	localparam logic [MAG_W-1:0] MAG_MAX  = {MAG_W{1'b1}};

	// one step of the digit-by-digit square root
	typedef struct packed {
		logic              oor;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [X_W-1:0]    xr;
	} cell_t;

	typedef struct packed {
		logic             oor;
		logic [MAG_W-1:0] magnitude;
	} out_t;

	function automatic logic [LG_W-1:0] clamp_lg(input logic [LG_W-1:0] lg);
		logic [LG_W-1:0] res;
		if (lg < LG_W'(MIN_FFT_LOG2))
			res = LG_W'(MIN_FFT_LOG2);
		else if (lg > LG_W'(MAX_FFT_LOG2))
			res = LG_W'(MAX_FFT_LOG2);
		else
			res = lg;
		return res;
	endfunction

	function automatic logic [SAMPLE_WIDTH-1:0] abs_sample(input logic [SAMPLE_WIDTH-1:0] v);
		logic [SAMPLE_WIDTH-1:0] res;
		// most negative value maps onto its own bit pattern, read unsigned
		if (v[SAMPLE_WIDTH-1])
			res = ~v + 1'b1;
		else
			res = v;
		return res;
	endfunction

endpackage

### src/ssms_front.sv
// ----------------------------------------------------------------------------
// ssms_front
// Bin classification, absolute values, squares and the radicand of the root.
// ----------------------------------------------------------------------------
module ssms_front import ssms_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [SAMPLE_WIDTH-1:0] real_part,
	input  logic [SAMPLE_WIDTH-1:0] imag_part,
	input  logic [IDX_W-1:0]        bin_index,
	input  logic [LG_W-1:0]         lg,
	output logic                    valid_o,
	output cell_t                   data_o
);

	logic [HALF_W-1:0]       half;
	logic                    oor_d;
	logic                    dbl_d;

	logic                    valid_s1;
	logic [SAMPLE_WIDTH-1:0] a_s1;
	logic [SAMPLE_WIDTH-1:0] b_s1;
	logic                    oor_s1;
	logic                    dbl_s1;

	logic                    valid_s2;
	logic [SQ_W-1:0]         aa_s2;
	logic [SQ_W-1:0]         bb_s2;
	logic                    oor_s2;
	logic                    dbl_s2;

	logic [SQ_W-1:0]         sum;
	logic [X_W-1:0]          radicand;

	always_comb begin
		half  = HALF_W'(1) << (lg - LG_W'(1));
		oor_d = CMP_W'(bin_index) > CMP_W'(half);
		// dc and nyquist bins are not doubled
		dbl_d = (bin_index != '0) && (CMP_W'(bin_index) != CMP_W'(half));
	end

	always_comb begin
		sum = aa_s2 + bb_s2;
		if (dbl_s2)
			radicand = X_W'(sum) << SHIFT_DOUBLE;
		else
			radicand = X_W'(sum) << SHIFT_PLAIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_o  <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_o  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1        <= abs_sample(real_part);
			b_s1        <= abs_sample(imag_part);
			oor_s1      <= oor_d;
			dbl_s1      <= dbl_d;
			aa_s2       <= SQ_W'(a_s1) * SQ_W'(a_s1);
			bb_s2       <= SQ_W'(b_s1) * SQ_W'(b_s1);
			oor_s2      <= oor_s1;
			dbl_s2      <= dbl_s1;
			data_o.oor  <= oor_s2;
			data_o.rem  <= '0;
			data_o.root <= '0;
			data_o.xr   <= radicand;
		end
	end

endmodule

### src/ssms_cell.sv
// ----------------------------------------------------------------------------
// ssms_cell
// One root bit of the restoring square root: brings down two radicand bits,
// tries the next root bit and passes the partial result on.
// ----------------------------------------------------------------------------
module ssms_cell import ssms_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_i,
	input  cell_t data_i,
	output logic  valid_o,
	output cell_t data_o
);

	logic [REM_W+1:0] r2;
	logic [REM_W+1:0] trial;
	cell_t            nxt;

	always_comb begin
		r2       = {data_i.rem, data_i.xr[X_W-1 -: 2]};
		trial    = (REM_W + 2)'({data_i.root, 2'b01});
		nxt.oor  = data_i.oor;
		nxt.xr   = {data_i.xr[X_W-3:0], 2'b00};
		if (r2 >= trial) begin
			nxt.rem  = REM_W'(r2 - trial);
			nxt.root = {data_i.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = REM_W'(r2);
			nxt.root = {data_i.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_o <= nxt;
		end
	end

endmodule

### src/ssms_out.sv
// ----------------------------------------------------------------------------
// ssms_out
// Scaling by the FFT length, saturation and a two-word output queue that
// decouples the chain from the downstream stall.
// ----------------------------------------------------------------------------
module ssms_out import ssms_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_i,
	input  cell_t            data_i,
	input  logic [LG_W-1:0]  lg,
	output logic             en,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [MAG_W-1:0] magnitude,
	output logic             oor
);

	logic [ROOT_W-1:0] shifted;
	out_t              word;
	out_t              mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic              pop;

	always_comb begin
		shifted = data_i.root >> lg;
		word.oor = data_i.oor;
		if (data_i.oor)
			word.magnitude = '0;
		else if (SAT_W'(shifted) > SAT_W'(MAG_MAX))
			word.magnitude = MAG_MAX;
		else
			word.magnitude = MAG_W'(shifted);
	end

	assign en       = (count_q != 2'd2);
	assign m_tvalid = (count_q != 2'd0);
	assign push     = valid_i && en;
	assign pop      = m_tvalid && m_tready;

	assign magnitude = mem_q[rd_ptr_q].magnitude;
	assign oor       = mem_q[rd_ptr_q].oor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= word;
	end

endmodule

### src/single_sided_magnitude_spectrum_unit.sv
// ----------------------------------------------------------------------------
// single_sided_magnitude_spectrum_unit
// Single-sided amplitude of one complex FFT bin per word: scale*sqrt(R^2+I^2)/N
// with 8 fraction bits, exact truncated root.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tdata: real_part, imag_part, bin_index
//  m_axis   | out       | tdata: magnitude; tuser: index_out_of_range
//  cfg      | in        | data: fft_size_log2
//
// one word per cycle sustained while the output queue is not full; each word
// passes through the chain of square-root cells, one root bit per cell.
// reset clears the valid bits of every stage and the output queue and sets
// fft_size_log2 to 10.
// a downstream stall fills the two-word output queue; s_tready drops only
// when both words are held, and the whole chain then holds its contents.
// ----------------------------------------------------------------------------
module single_sided_magnitude_spectrum_unit import ssms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // real_part, imag_part, bin_index
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // magnitude, zero fill
	output logic                 m_tuser,   // index_out_of_range
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [LG_W-1:0]      cfg_data   // fft_size_log2
);

	logic [LG_W-1:0]  fft_size_log2_q;
	logic [LG_W-1:0]  lg;
	logic             en;
	logic             chain_valid [ROOT_W+1];
	cell_t            chain_data  [ROOT_W+1];
	logic [MAG_W-1:0] magnitude;
	logic             oor;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fft_size_log2_q <= LG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			fft_size_log2_q <= cfg_data;
		end
	end

	assign lg       = clamp_lg(fft_size_log2_q);
	assign s_tready = en;

	ssms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.real_part (s_tdata[SAMPLE_WIDTH-1:0]),
		.imag_part (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
		.bin_index (s_tdata[2*SAMPLE_WIDTH+IDX_W-1:2*SAMPLE_WIDTH]),
		.lg        (lg),
		.valid_o   (chain_valid[0]),
		.data_o    (chain_data[0])
	);

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		ssms_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (chain_valid[i]),
			.data_i  (chain_data[i]),
			.valid_o (chain_valid[i+1]),
			.data_o  (chain_data[i+1])
		);
	end

	ssms_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_i   (chain_valid[ROOT_W]),
		.data_i    (chain_data[ROOT_W]),
		.lg        (lg),
		.en        (en),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.magnitude (magnitude),
		.oor       (oor)
	);

	assign m_tdata = M_TDATA_W'(magnitude);
	assign m_tuser = oor;

endmodule

### src/ssms_checker.sv
// ----------------------------------------------------------------------------
// ssms_checker
// Port-level checks of the magnitude spectrum unit, bound to the top level.
// ----------------------------------------------------------------------------
module ssms_checker import ssms_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [LG_W-1:0]      cfg_data
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// out-of-range bins carry a zero magnitude
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("out-of-range bin with non-zero magnitude");

	// input back-pressure only comes from a full output queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output word pending");

	// fill bits above the magnitude stay zero
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata >> MAG_W) == '0)
		else $error("non-zero fill bits in output word");

endmodule

bind single_sided_magnitude_spectrum_unit ssms_checker u_ssms_checker (.*);

### tb/single_sided_magnitude_spectrum_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// single_sided_magnitude_spectrum_checker
// Watches the bin, result and config channels of the magnitude spectrum unit.
// Every accepted bin gets its single-sided amplitude worked out with an exact
// truncated integer root, and result words are compared against these in order.
// ----------------------------------------------------------------------------
module single_sided_magnitude_spectrum_checker import ssms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // real_part, imag_part, bin_index
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,   // magnitude, zero fill
	input  logic                 m_tuser,   // index_out_of_range
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [LG_W-1:0]      cfg_data,  // fft_size_log2
	output int                   mismatch_count,
	output int                   bins_in_flight
);

	localparam int RAD_W = 2 * SAMPLE_WIDTH + SHIFT_DOUBLE;
	localparam int RT_W  = RAD_W / 2 + 1;
	localparam int SQ2_W = 2 * RT_W;

	typedef struct packed {
		logic             beyond_nyquist;
		logic [MAG_W-1:0] amplitude;
	} amp_word_t;

	amp_word_t       expected_amps[$];
	amp_word_t       oldest_amp;
	logic [LG_W-1:0] fft_lg;

	function automatic amp_word_t predict_amplitude(input logic [S_TDATA_W-1:0] word,
			input logic [LG_W-1:0] lg_reg);
		logic [LG_W-1:0]         lg;
		logic [SAMPLE_WIDTH-1:0] re;
		logic [SAMPLE_WIDTH-1:0] im;
		logic [SAMPLE_WIDTH-1:0] re_abs;
		logic [SAMPLE_WIDTH-1:0] im_abs;
		logic [IDX_W-1:0]        bin;
		logic [IDX_W-1:0]        nyquist;
		logic [RAD_W-1:0]        radicand;
		logic [RT_W-1:0]         root;
		logic [RT_W-1:0]         trial;
		logic [SQ2_W-1:0]        trial_sq;
		amp_word_t               res;
		re  = word[SAMPLE_WIDTH-1:0];
		im  = word[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
		bin = word[2*SAMPLE_WIDTH +: IDX_W];
		if (lg_reg < LG_W'(MIN_FFT_LOG2))
			lg = LG_W'(MIN_FFT_LOG2);
		else if (lg_reg > LG_W'(MAX_FFT_LOG2))
			lg = LG_W'(MAX_FFT_LOG2);
		else
			lg = lg_reg;
		nyquist = IDX_W'(1) << (lg - 1'b1);
		res.beyond_nyquist = 1'b0;
		res.amplitude      = '0;
		if (bin > nyquist) begin
			res.beyond_nyquist = 1'b1;
		end else begin
			// the most negative sample keeps its pattern, which reads as 2^(w-1)
			re_abs   = re[SAMPLE_WIDTH-1] ? ~re + 1'b1 : re;
			im_abs   = im[SAMPLE_WIDTH-1] ? ~im + 1'b1 : im;
			radicand = RAD_W'(re_abs) * RAD_W'(re_abs) + RAD_W'(im_abs) * RAD_W'(im_abs);
			// 8 fraction bits, plus the factor two on interior bins
			if (bin == '0 || bin == nyquist)
				radicand = radicand << SHIFT_PLAIN;
			else
				radicand = radicand << SHIFT_DOUBLE;
			root = '0;
			for (int b = RT_W - 1; b >= 0; b--) begin
				trial    = root | (RT_W'(1) << b);
				trial_sq = SQ2_W'(trial) * SQ2_W'(trial);
				if (trial_sq <= SQ2_W'(radicand))
					root = trial;
			end
			root = root >> lg;
			if (root > RT_W'(MAG_MAX))
				res.amplitude = MAG_MAX;
			else
				res.amplitude = root[MAG_W-1:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fft_lg = LG_RESET;
			expected_amps.delete();
			bins_in_flight = 0;
			mismatch_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_amps.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result word with no bin outstanding: mag %0d oor %0b",
							$time, m_tdata[MAG_W-1:0], m_tuser);
					mismatch_count++;
				end else begin
					oldest_amp = expected_amps.pop_front();
					if (oldest_amp.amplitude !== m_tdata[MAG_W-1:0] ||
							oldest_amp.beyond_nyquist !== m_tuser) begin
						if (mismatch_count < 10)
							$display("%0t: mismatch: expected mag %0d oor %0b, got mag %0d oor %0b",
								$time, oldest_amp.amplitude, oldest_amp.beyond_nyquist,
								m_tdata[MAG_W-1:0], m_tuser);
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_amps = {expected_amps, predict_amplitude(s_tdata, fft_lg)};
			if (cfg_valid && cfg_ready)
				fft_lg = cfg_data;
			bins_in_flight = expected_amps.size();
		end
	end

endmodule

### tb/single_sided_magnitude_spectrum_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// single_sided_magnitude_spectrum_unit_tb
// Drives FFT bins through the magnitude spectrum unit under several FFT sizes
// and back-pressure mixes; a side checker predicts and compares each result.
// ----------------------------------------------------------------------------
module single_sided_magnitude_spectrum_unit_tb;
	import ssms_pkg::*;

	localparam int STALL_LIMIT      = 2000;
	localparam int BINS_PER_SETTING = 212;
	localparam int SETTLE_CYCLES    = ROOT_W + 8;

	localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic [SAMPLE_WIDTH-1:0] S_ONE = SAMPLE_WIDTH'(1);
	localparam logic [SAMPLE_WIDTH-1:0] S_NEG = '1;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 m_tready  = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [LG_W-1:0]      cfg_data  = '0;
	wire                  s_tready;
	wire                  m_tvalid;
	wire  [M_TDATA_W-1:0] m_tdata;
	wire                  m_tuser;
	wire                  cfg_ready;

	int mismatch_count;
	int bins_in_flight;
	int tx_idle_pct  = 0;
	int rx_idle_pct  = 0;
	int quiet_cycles = 0;

	logic [LG_W-1:0] lg_plan [8];

	always #2 clk = ~clk;

	single_sided_magnitude_spectrum_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	single_sided_magnitude_spectrum_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.bins_in_flight (bins_in_flight)
	);

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// any handshake counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called and returns at a falling edge; tvalid stays high for a following word
	task automatic send_bin(input logic [SAMPLE_WIDTH-1:0] re, input logic [SAMPLE_WIDTH-1:0] im,
			input logic [IDX_W-1:0] bin);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {bin, im, re};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (bins_in_flight != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_fft_lg(input logic [LG_W-1:0] lg);
		cfg_valid <= 1'b1;
		cfg_data  <= lg;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
		logic [SAMPLE_WIDTH-1:0] v;
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(4))
					0: v = S_MAX;
					1: v = S_MIN;
					2: v = '0;
					3: v = S_NEG;
					default: v = S_ONE;
				endcase
			end
			1: begin
				v = SAMPLE_WIDTH'($urandom_range(255));
				if ($urandom_range(1))
					v = -v;
			end
			default: v = SAMPLE_WIDTH'($urandom);
		endcase
		return v;
	endfunction

	// dc, nyquist and its neighbours come up far more often than chance
	function automatic logic [IDX_W-1:0] rand_bin(input logic [IDX_W-1:0] nyq);
		logic [IDX_W-1:0] b;
		case ($urandom_range(19))
			0, 1: b = '0;
			2, 3: b = nyq;
			4: b = nyq - 1'b1;
			5: b = nyq + 1'b1;
			6, 7: b = IDX_W'($urandom);
			8: b = '1;
			default: b = IDX_W'($urandom_range(nyq - 1, 1));
		endcase
		return b;
	endfunction

	initial begin
		logic [LG_W-1:0]  eff_lg;
		logic [IDX_W-1:0] nyq;
		lg_plan = '{LG_W'(3), LG_W'(16), LG_W'(0), LG_W'(31),
			LG_W'(7), LG_W'(12), LG_W'(2), LG_W'(17)};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		tx_idle_pct = 20;
		rx_idle_pct = 88;

		// reset setting, N = 1024 and nyquist bin 512
		send_bin('0, '0, IDX_W'(0));
		send_bin(S_MAX, S_MAX, IDX_W'(1));
		send_bin(S_MIN, S_MIN, IDX_W'(1));
		send_bin(S_MIN, '0, IDX_W'(0));
		send_bin('0, S_MIN, IDX_W'(512));
		send_bin(S_MAX, S_MIN, IDX_W'(511));
		send_bin(S_NEG, S_ONE, IDX_W'(513));
		send_bin(S_ONE, S_NEG, '1);
		send_bin(SAMPLE_WIDTH'(3), SAMPLE_WIDTH'(4), IDX_W'(0));
		send_bin(SAMPLE_WIDTH'(3), SAMPLE_WIDTH'(4), IDX_W'(100));
		send_bin(-SAMPLE_WIDTH'(3), -SAMPLE_WIDTH'(4), IDX_W'(512));
		send_bin(S_ONE, '0, IDX_W'(1));
		send_bin(S_MAX, '0, IDX_W'(512));
		send_bin(S_MIN, S_MAX, IDX_W'(0));
		send_bin(rand_sample(), rand_sample(), IDX_W'(32768));
		send_bin(SAMPLE_WIDTH'(12345), -SAMPLE_WIDTH'(6789), IDX_W'(257));

		for (int p = 0; p < 8; p++) begin
			drain_results();
			write_fft_lg(lg_plan[p]);
			if (p == 3) begin
				tx_idle_pct = 88;
				rx_idle_pct = 20;
			end else if (p == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (lg_plan[p] < LG_W'(MIN_FFT_LOG2))
				eff_lg = LG_W'(MIN_FFT_LOG2);
			else if (lg_plan[p] > LG_W'(MAX_FFT_LOG2))
				eff_lg = LG_W'(MAX_FFT_LOG2);
			else
				eff_lg = lg_plan[p];
			nyq = IDX_W'(1) << (eff_lg - 1'b1);
			for (int i = 0; i < BINS_PER_SETTING; i++) begin
				// hold the source until the pipe has fully emptied
				if (p == 0 && i == BINS_PER_SETTING / 2)
					drain_results();
				send_bin(rand_sample(), rand_sample(), rand_bin(nyq));
			end
		end
		drain_results();

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
